### rtl/core/swld_pkg.sv
// Package: shared constants, types and state encoding for the LZ77 window decoder.
package swld_pkg;

    localparam int HIST_DEPTH = 256;
    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int LEN_W = 6;
    localparam int BYTE_W = 8;

    localparam logic [LEN_W-1:0] MAX_MATCH = 6'd63;
    localparam logic [BYTE_W-1:0] WINDOW_RESET = 8'd100;
    localparam logic [BYTE_W-1:0] COUNT_SAT = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_LIT
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [HIST_AW-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [HIST_AW-1:0] raddr;
    } mem_req_t;

endpackage

### rtl/core/swld_if.sv
// Interfaces: the token input channel and the decoded byte output channel.
interface swld_tok_if;
    logic       valid;
    logic       ready;
    logic [5:0] match_length;
    logic [7:0] match_offset;
    logic [7:0] literal_byte;

    modport source (output valid, output match_length, output match_offset,
                    output literal_byte, input ready);
    modport sink (input valid, input match_length, input match_offset,
                  input literal_byte, output ready);
endinterface

interface swld_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    logic       bad_reference;

    modport source (output valid, output data_byte, output last,
                    output bad_reference, input ready);
    modport sink (input valid, input data_byte, input last,
                  input bad_reference, output ready);
endinterface

### rtl/core/swld_hist_mem.sv
// History memory: byte store of the decoded output with one write port and one registered read port.
module swld_hist_mem (
    input  logic                              clk,
    input  swld_pkg::mem_req_t                req,
    output logic [swld_pkg::BYTE_W-1:0]       rdata
);

    logic [swld_pkg::BYTE_W-1:0] mem [swld_pkg::HIST_DEPTH];
    logic [swld_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/swld_seq.sv
// Sequencer: walks one token through setup, copy and literal steps around the history memory.
module swld_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [swld_pkg::BYTE_W-1:0]   window_size,
    swld_tok_if.sink                      tok,
    swld_byte_if.source                   dout,
    output swld_pkg::mem_req_t            mem_req,
    input  logic [swld_pkg::BYTE_W-1:0]   mem_rdata
);

    swld_pkg::seq_state_t state_reg, state_next;
    logic [swld_pkg::LEN_W-1:0]   cnt_reg, cnt_next;
    logic [swld_pkg::BYTE_W-1:0]  off_reg, off_next;
    logic [swld_pkg::BYTE_W-1:0]  lit_reg, lit_next;
    logic [swld_pkg::HIST_AW-1:0] wp_reg, wp_next;
    logic [swld_pkg::BYTE_W-1:0]  bw_reg, bw_next;
    logic                         wrapped_reg, wrapped_next;
    logic [swld_pkg::HIST_AW-1:0] rd_addr_reg, rd_addr_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic                         bad_reg, bad_next;
    logic                         ov_reg, ov_next;
    logic [swld_pkg::BYTE_W-1:0]  od_reg, od_next;
    logic                         ol_reg, ol_next;
    logic                         ob_reg, ob_next;

    logic                         slot_free;
    logic [swld_pkg::BYTE_W-1:0]  filled;
    logic                         do_write;
    logic [swld_pkg::BYTE_W-1:0]  wr_byte;
    logic [swld_pkg::LEN_W-1:0]   len_sat;

    assign slot_free = !ov_reg || dout.ready;
    assign filled = (bw_reg < window_size) ? bw_reg : window_size;
    assign len_sat = (tok.match_length > swld_pkg::MAX_MATCH) ? swld_pkg::MAX_MATCH
                                                               : tok.match_length;

    assign tok.ready          = (state_reg == swld_pkg::ST_IDLE);
    assign dout.valid         = ov_reg;
    assign dout.data_byte     = od_reg;
    assign dout.last          = ol_reg;
    assign dout.bad_reference = ob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= swld_pkg::ST_IDLE;
            wp_reg      <= '0;
            bw_reg      <= '0;
            wrapped_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            bw_reg      <= bw_next;
            wrapped_reg <= wrapped_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        off_reg      <= off_next;
        lit_reg      <= lit_next;
        rd_addr_reg  <= rd_addr_next;
        rd_valid_reg <= rd_valid_next;
        bad_reg      <= bad_next;
        od_reg       <= od_next;
        ol_reg       <= ol_next;
        ob_reg       <= ob_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        off_next      = off_reg;
        lit_next      = lit_reg;
        wp_next       = wp_reg;
        bw_next       = bw_reg;
        wrapped_next  = wrapped_reg;
        rd_addr_next  = rd_addr_reg;
        rd_valid_next = rd_valid_reg;
        bad_next      = bad_reg;
        ov_next       = ov_reg && !dout.ready;
        od_next       = od_reg;
        ol_next       = ol_reg;
        ob_next       = ob_reg;
        do_write      = 1'b0;
        wr_byte       = lit_reg;
        mem_req.re    = 1'b0;
        mem_req.raddr = rd_addr_reg;

        case (state_reg)
            swld_pkg::ST_IDLE:
            begin
                if (tok.valid)
                begin
                    cnt_next   = len_sat;
                    off_next   = tok.match_offset;
                    lit_next   = tok.literal_byte;
                    state_next = swld_pkg::ST_SETUP;
                end
            end
            swld_pkg::ST_SETUP:
            begin
                // The window start is frozen here for the whole token.
                bad_next     = (off_reg >= filled);
                rd_addr_next = wp_reg - filled + off_reg;
                state_next   = (cnt_reg == '0) ? swld_pkg::ST_LIT : swld_pkg::ST_COPY_RD;
            end
            swld_pkg::ST_COPY_RD:
            begin
                mem_req.re = 1'b1;
                // An entry never written since reset reads as zero.
                rd_valid_next = wrapped_reg || (rd_addr_reg < wp_reg);
                state_next    = swld_pkg::ST_COPY_WR;
            end
            swld_pkg::ST_COPY_WR:
            begin
                if (slot_free)
                begin
                    wr_byte      = rd_valid_reg ? mem_rdata : '0;
                    do_write     = 1'b1;
                    ov_next      = 1'b1;
                    od_next      = wr_byte;
                    ol_next      = 1'b0;
                    ob_next      = bad_reg;
                    rd_addr_next = rd_addr_reg + 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                    state_next   = (cnt_reg == 6'd1) ? swld_pkg::ST_LIT : swld_pkg::ST_COPY_RD;
                end
            end
            swld_pkg::ST_LIT:
            begin
                if (slot_free)
                begin
                    wr_byte    = lit_reg;
                    do_write   = 1'b1;
                    ov_next    = 1'b1;
                    od_next    = lit_reg;
                    ol_next    = 1'b1;
                    ob_next    = 1'b0;
                    state_next = swld_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swld_pkg::ST_IDLE;
            end
        endcase

        if (do_write)
        begin
            wp_next = wp_reg + 1'b1;
            if (bw_reg != swld_pkg::COUNT_SAT)
            begin
                bw_next = bw_reg + 1'b1;
            end
            if (wp_reg == {swld_pkg::HIST_AW{1'b1}})
            begin
                wrapped_next = 1'b1;
            end
        end

        mem_req.we    = do_write;
        mem_req.waddr = wp_reg;
        mem_req.wdata = wr_byte;
    end

endmodule

### rtl/core/sliding_window_lz77_decoder.sv
// Top level: LZ77 token decoder with a sliding window over a 256-byte output history.
//
// Tokens arrive on tok (valid/ready); each carries a match length, an offset
// counted from the window start, and a literal byte. Decoded bytes leave on
// dout (valid/ready), one word per byte: the copied bytes first, then the
// literal with last set. bad_reference marks copied bytes of a token whose
// offset is not below the filled window size.
// The window size register must be written through cfg_we/cfg_wdata only while idle;
// the block does not enforce this. It takes effect at the next token; it resets to 100.
// A token passes through these steps: accept, fix the window start, then per copied byte
// a memory read followed by write-back and output, and last the literal. tok.ready is
// high only between tokens.
// Reset empties the history at once: entries not yet written read as zero,
// tracked by the write pointer and a wrap flag, so there is no clearing pass.
// When the receiver stalls, the output register holds its word and the
// decoder waits before producing the next byte.
module sliding_window_lz77_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    swld_tok_if.sink             tok,
    swld_byte_if.source          dout,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata
);

    logic [swld_pkg::BYTE_W-1:0] window_size_reg, window_size_next;
    swld_pkg::mem_req_t          mem_req;
    logic [swld_pkg::BYTE_W-1:0] mem_rdata;

    assign window_size_next = cfg_we ? cfg_wdata : window_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swld_pkg::WINDOW_RESET;
        end
        else
        begin
            window_size_reg <= window_size_next;
        end
    end

    swld_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .window_size (window_size_reg),
        .tok         (tok),
        .dout        (dout),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    swld_hist_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule
